>>> sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the block bitmap allocator
// Holds the request and response item types, the operation, status and
// register codes, and the fixed sizes of the block address space.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int MAX_BLOCKS = 4096;
	localparam int BLK_W      = 12;   // block index width
	localparam int CNT_W      = 13;   // block count width, holds MAX_BLOCKS
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [1:0] {
		MODE_INIT  = 2'd0,
		MODE_ALLOC = 2'd1,
		MODE_FREE  = 2'd2,
		MODE_QUERY = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_INVALID  = 2'd2,
		ST_DBL_FREE = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TOTAL_BLOCKS      = 3'd0,
		CFG_FIRST_DATA_BLOCK  = 3'd1,
		CFG_INODE_MAP_START   = 3'd2,
		CFG_INODE_MAP_COUNT   = 3'd3,
		CFG_BLOCK_MAP_START   = 3'd4,
		CFG_BLOCK_MAP_COUNT   = 3'd5,
		CFG_INODE_TABLE_START = 3'd6,
		CFG_INODE_TABLE_COUNT = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		mode_t            mode;
		logic [BLK_W-1:0] block_index;
	} req_item_t;

	typedef struct packed {
		status_t          status;
		logic [BLK_W-1:0] result_block;
		logic             is_used;
		logic [CNT_W-1:0] free_count;
	} rsp_item_t;

endpackage

>>> sv/block_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// block_bitmap_allocator: first-fit block allocator over an occupancy bitmap
// Keeps one used bit per block in a RAM of WORD_BITS-wide words plus a
// running free block counter, and serves init, allocate, free and query.
// ----------------------------------------------------------------------------
// Operation: items are handled one at a time, and every item yields exactly
// one response. Free and query read the map word, check it and, for a valid
// free, write it back, then load the response register. Allocate reads one
// map word per cycle through the single RAM read port, starting at the word
// of first_data_block and stopping at the first word with a free data block
// or at the word of the last block, then loads the response register. When
// first_data_block lies at or past the total, allocate reads nothing and goes
// straight to loading the response register. Init rewrites every map word
// once. After reset the map is cleared the same way, one word per cycle, and
// no request is taken until that pass ends.
// Configuration writes are always taken and must only come while idle.
module block_bitmap_allocator #(
	parameter int WORD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  bba_pkg::req_item_t            req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output bba_pkg::rsp_item_t            rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bba_pkg::CNT_W-1:0]     cfg_data
);

	localparam int BLK_W     = bba_pkg::BLK_W;
	localparam int CNT_W     = bba_pkg::CNT_W;
	localparam int MAP_WORDS = bba_pkg::MAX_BLOCKS / WORD_BITS;
	localparam int BW        = $clog2(WORD_BITS);
	localparam int AW        = BLK_W - BW;
	localparam int OFF_W     = BW + 1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_INIT,
		S_SCAN,
		S_CHECK,
		S_PUSH
	} state_t;

	// Offset of value v inside the word starting at base, clipped to [0, WORD_BITS].
	function automatic logic [OFF_W-1:0] clip_off(input logic [CNT_W-1:0] v,
		input logic [CNT_W-1:0] base);
		logic [CNT_W-1:0] d;
		logic [OFF_W-1:0] r;
		d = v - base;
		if (v <= base) begin
			r = '0;
		end else if (d >= CNT_W'(WORD_BITS)) begin
			r = OFF_W'(WORD_BITS);
		end else begin
			r = d[OFF_W-1:0];
		end
		return r;
	endfunction

	// Bits of the word at base whose block lies in [lo, hi).
	function automatic logic [WORD_BITS-1:0] range_mask(input logic [CNT_W-1:0] lo,
		input logic [CNT_W-1:0] hi, input logic [CNT_W-1:0] base);
		logic [OFF_W-1:0]     lo_off;
		logic [OFF_W-1:0]     hi_off;
		logic [WORD_BITS-1:0] m;
		lo_off = clip_off(lo, base);
		hi_off = clip_off(hi, base);
		for (int i = 0; i < WORD_BITS; i++) begin
			m[i] = (OFF_W'(i) >= lo_off) && (OFF_W'(i) < hi_off);
		end
		return m;
	endfunction

	// End of a region, clipped to the block total. The sum is one bit wider so
	// that a large start plus a large count cannot wrap.
	function automatic logic [CNT_W-1:0] region_end(input logic [BLK_W-1:0] start,
		input logic [CNT_W-1:0] count, input logic [CNT_W-1:0] t);
		logic [CNT_W:0] e;
		e = (CNT_W+1)'(start) + (CNT_W+1)'(count);
		return (e < (CNT_W+1)'(t)) ? e[CNT_W-1:0] : t;
	endfunction

	function automatic logic [BW-1:0] lowest_index(input logic [WORD_BITS-1:0] v);
		logic [BW-1:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = BW'(i);
			end
		end
		return r;
	endfunction

	state_t             state_q;
	logic [AW-1:0]      sweep_q;
	logic [CNT_W-1:0]   free_q;
	logic               rsp_valid_q;
	bba_pkg::rsp_item_t rsp_q;
	bba_pkg::rsp_item_t res_q;
	bba_pkg::mode_t     op_q;
	logic [BLK_W-1:0]   idx_q;
	logic [AW-1:0]      last_word_q;
	logic [AW:0]        rd_word_q;
	logic [AW-1:0]      word_s1;
	logic               vld_s1;

	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] first_data_q;
	logic [BLK_W-1:0] imap_start_q;
	logic [CNT_W-1:0] imap_count_q;
	logic [BLK_W-1:0] bmap_start_q;
	logic [CNT_W-1:0] bmap_count_q;
	logic [BLK_W-1:0] itab_start_q;
	logic [CNT_W-1:0] itab_count_q;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata;

	logic                 req_fire;
	logic [CNT_W-1:0]     eff_total;
	logic [CNT_W-1:0]     total_m1;
	logic [CNT_W-1:0]     sweep_base;
	logic [CNT_W-1:0]     scan_base;
	logic [WORD_BITS-1:0] init_word;
	logic [CNT_W+1:0]     meta_sum;
	logic [CNT_W+1:0]     free_diff;
	logic [CNT_W-1:0]     init_free;
	logic                 scan_issue;
	logic [WORD_BITS-1:0] scan_cand;
	logic [WORD_BITS-1:0] grant_bit;
	logic [BW-1:0]        grant_idx;
	logic                 scan_hit;
	logic                 chk_bit;
	logic [WORD_BITS-1:0] chk_onehot;
	logic                 chk_invalid;
	logic                 free_ok;
	logic                 out_free;

	bba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign req_stall = (state_q != S_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign eff_total = (total_q > CNT_W'(bba_pkg::MAX_BLOCKS)) ?
		CNT_W'(bba_pkg::MAX_BLOCKS) : total_q;
	assign total_m1  = eff_total - CNT_W'(1);

	// Init word: block 0 and the three metadata regions, all clipped to the total.
	assign sweep_base = {1'b0, sweep_q, {BW{1'b0}}};
	assign init_word =
		range_mask('0, (eff_total != '0) ? CNT_W'(1) : '0, sweep_base) |
		range_mask({1'b0, imap_start_q},
			region_end(imap_start_q, imap_count_q, eff_total), sweep_base) |
		range_mask({1'b0, bmap_start_q},
			region_end(bmap_start_q, bmap_count_q, eff_total), sweep_base) |
		range_mask({1'b0, itab_start_q},
			region_end(itab_start_q, itab_count_q, eff_total), sweep_base);

	// Metadata counts are taken in full, even where regions overlap or are clipped.
	assign meta_sum  = (CNT_W+2)'(1) + (CNT_W+2)'(imap_count_q) +
		(CNT_W+2)'(bmap_count_q) + (CNT_W+2)'(itab_count_q);
	assign free_diff = (CNT_W+2)'(eff_total) - meta_sum;
	assign init_free = ((CNT_W+2)'(eff_total) > meta_sum) ? free_diff[CNT_W-1:0] : '0;

	// Allocation scan: candidates are free bits with first_data <= block < total.
	assign scan_issue = (rd_word_q <= {1'b0, last_word_q});
	assign scan_base  = {1'b0, word_s1, {BW{1'b0}}};
	assign scan_cand  = ~mem_rdata & range_mask(first_data_q, eff_total, scan_base);
	assign grant_bit  = scan_cand & (~scan_cand + WORD_BITS'(1));
	assign grant_idx  = lowest_index(scan_cand);
	assign scan_hit   = vld_s1 && (scan_cand != '0);

	assign chk_onehot  = WORD_BITS'(1) << idx_q[BW-1:0];
	assign chk_bit     = mem_rdata[idx_q[BW-1:0]];
	assign chk_invalid = ({1'b0, idx_q} < first_data_q) || ({1'b0, idx_q} >= eff_total);
	assign free_ok     = (op_q == bba_pkg::MODE_FREE) && !chk_invalid && chk_bit;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = sweep_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = rd_word_q[AW-1:0];
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = init_word;
			end
			S_IDLE: begin
				mem_re    = req_fire && (req.mode inside {bba_pkg::MODE_FREE,
					bba_pkg::MODE_QUERY});
				mem_raddr = req.block_index[BLK_W-1:BW];
			end
			S_SCAN: begin
				mem_re    = scan_issue;
				mem_we    = scan_hit;
				mem_waddr = word_s1;
				mem_wdata = mem_rdata | grant_bit;
			end
			S_CHECK: begin
				mem_we    = free_ok;
				mem_waddr = idx_q[BLK_W-1:BW];
				mem_wdata = mem_rdata & ~chk_onehot;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			sweep_q      <= '0;
			free_q       <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
			res_q        <= '0;
			op_q         <= bba_pkg::MODE_INIT;
			idx_q        <= '0;
			last_word_q  <= '0;
			rd_word_q    <= '0;
			word_s1      <= '0;
			vld_s1       <= 1'b0;
			total_q      <= CNT_W'(bba_pkg::MAX_BLOCKS);
			first_data_q <= '0;
			imap_start_q <= '0;
			imap_count_q <= '0;
			bmap_start_q <= '0;
			bmap_count_q <= '0;
			itab_start_q <= '0;
			itab_count_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bba_pkg::CFG_TOTAL_BLOCKS:      total_q      <= cfg_data;
					bba_pkg::CFG_FIRST_DATA_BLOCK:  first_data_q <= cfg_data;
					bba_pkg::CFG_INODE_MAP_START:   imap_start_q <= cfg_data[BLK_W-1:0];
					bba_pkg::CFG_INODE_MAP_COUNT:   imap_count_q <= cfg_data;
					bba_pkg::CFG_BLOCK_MAP_START:   bmap_start_q <= cfg_data[BLK_W-1:0];
					bba_pkg::CFG_BLOCK_MAP_COUNT:   bmap_count_q <= cfg_data;
					bba_pkg::CFG_INODE_TABLE_START: itab_start_q <= cfg_data[BLK_W-1:0];
					bba_pkg::CFG_INODE_TABLE_COUNT: itab_count_q <= cfg_data;
					default: begin
					end
				endcase
			end

			if (state_q == S_PUSH && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == AW'(MAP_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						op_q  <= req.mode;
						idx_q <= req.block_index;
						case (req.mode)
							bba_pkg::MODE_INIT: begin
								sweep_q <= '0;
								state_q <= S_INIT;
							end
							bba_pkg::MODE_ALLOC: begin
								rd_word_q   <= {1'b0, first_data_q[BLK_W-1:BW]};
								last_word_q <= total_m1[BLK_W-1:BW];
								vld_s1      <= 1'b0;
								if (first_data_q >= eff_total) begin
									res_q.status <= bba_pkg::ST_NO_SPACE;
									state_q      <= S_PUSH;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								state_q <= S_CHECK;
							end
						endcase
					end
				end
				S_INIT: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == AW'(MAP_WORDS - 1)) begin
						free_q  <= init_free;
						state_q <= S_PUSH;
					end
				end
				S_SCAN: begin
					vld_s1  <= scan_issue;
					word_s1 <= rd_word_q[AW-1:0];
					if (scan_issue) begin
						rd_word_q <= rd_word_q + (AW+1)'(1);
					end
					if (scan_hit) begin
						res_q.result_block <= {word_s1, grant_idx};
						if (free_q != '0) begin
							free_q <= free_q - CNT_W'(1);
						end
						state_q <= S_PUSH;
					end else if (vld_s1 && (word_s1 == last_word_q)) begin
						res_q.status <= bba_pkg::ST_NO_SPACE;
						state_q      <= S_PUSH;
					end
				end
				S_CHECK: begin
					if (op_q == bba_pkg::MODE_QUERY) begin
						res_q.is_used <= ({1'b0, idx_q} >= eff_total) || chk_bit;
					end else if (chk_invalid) begin
						res_q.status <= bba_pkg::ST_INVALID;
					end else if (!chk_bit) begin
						res_q.status <= bba_pkg::ST_DBL_FREE;
					end else if (free_q < CNT_W'(bba_pkg::MAX_BLOCKS)) begin
						free_q <= free_q + CNT_W'(1);
					end
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					// The response register takes the result once it is empty or
					// its current transfer completes this cycle. The result
					// register is cleared for the next item.
					if (out_free) begin
						rsp_q   <= {res_q.status, res_q.result_block, res_q.is_used, free_q};
						res_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The scan never writes back the word it is about to read.
	a_no_rw_same_word: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && mem_re |-> mem_waddr != mem_raddr)
		else $error("map word written and read in the same cycle");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= CNT_W'(bba_pkg::MAX_BLOCKS))
		else $error("free counter above the block limit");

	a_grant_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN && scan_hit |->
			{1'b0, word_s1, grant_idx} >= first_data_q &&
			{1'b0, word_s1, grant_idx} < eff_total)
		else $error("granted block outside the data area");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> state_q != S_IDLE && state_q != S_CLEAR)
		else $error("accepted request was dropped");

endmodule

>>> sv/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram: generic synchronous RAM
// One write port and one read port; read data is registered, so it appears
// in the cycle after the read address is presented.
// ----------------------------------------------------------------------------
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> dv/tb_block_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// tb_block_bitmap_allocator: self-checking bench for the block bitmap allocator
// A table of directed requests covers the corner cases of init, allocate, free
// and query. Random rounds follow, each with fresh registers and an init. Each
// response is checked field by field against its table row or a behavioral
// copy of the map and free counter, mostly with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_block_bitmap_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CNT_W         = bba_pkg::CNT_W;
	localparam int BLK_W         = bba_pkg::BLK_W;
	localparam int MAX_BLOCKS    = bba_pkg::MAX_BLOCKS;
	localparam int CFG_IDX_W     = bba_pkg::CFG_IDX_W;
	localparam int CFG_REGS      = 8;
	localparam int RANDOM_ITEMS  = 1100;
	localparam int SETTLE_CYCLES = 16;
	localparam int LONG_HOLD     = 400;
	localparam int QUIET_LIMIT   = 4000;

	typedef logic [CNT_W-1:0] reg_set_t [CFG_REGS];

	typedef struct {
		bba_pkg::mode_t     mode;
		logic [BLK_W-1:0]   block_index;
		int                 reg_set;     // register setting to load first, or -1
		bit                 typed;       // expected response given in the row
		bba_pkg::rsp_item_t want;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	bba_pkg::req_item_t   req;
	logic                 rsp_valid;
	logic                 rsp_stall;
	bba_pkg::rsp_item_t   rsp;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CNT_W-1:0]     cfg_data;

	// Behavioral copy of the allocator state and its registers.
	logic [MAX_BLOCKS-1:0] occ_map;
	int unsigned           free_ctr;
	logic [CNT_W-1:0]      vol_total, data_floor, imap_len, bmap_len, itab_len;
	logic [BLK_W-1:0]      imap_start, bmap_start, itab_start;

	bba_pkg::rsp_item_t due_rsp_q[$];
	int                 granted_q[$];
	int                 fail_count;
	int                 send_gap_pct;
	int                 recv_gap_pct;
	int                 hold_requests;
	int                 quiet_cycles;

	block_bitmap_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int volume_size();
		return (vol_total > MAX_BLOCKS) ? MAX_BLOCKS : int'(vol_total);
	endfunction

	// Regions are clipped at the volume end but still count in full toward the
	// metadata total.
	function automatic void mark_used(int start, int count);
		for (int j = 0; j < count; j++) begin
			if (start + j >= volume_size())
				break;
			occ_map[start + j] = 1'b1;
		end
	endfunction

	function automatic bba_pkg::rsp_item_t allocator_outcome(bba_pkg::req_item_t r);
		bba_pkg::rsp_item_t o;
		int                 t;
		int                 meta;
		o = '0;
		t = volume_size();
		case (r.mode)
			bba_pkg::MODE_INIT: begin
				occ_map = '0;
				mark_used(0, 1);
				mark_used(imap_start, imap_len);
				mark_used(bmap_start, bmap_len);
				mark_used(itab_start, itab_len);
				meta = 1 + imap_len + bmap_len + itab_len;
				free_ctr = (t > meta) ? t - meta : 0;
				granted_q.delete();
			end
			bba_pkg::MODE_ALLOC: begin
				o.status = bba_pkg::ST_NO_SPACE;
				for (int b = data_floor; b < t; b++) begin
					if (!occ_map[b]) begin
						occ_map[b] = 1'b1;
						if (free_ctr > 0)
							free_ctr--;
						o.status = bba_pkg::ST_OK;
						o.result_block = b[BLK_W-1:0];
						granted_q.push_back(b);
						break;
					end
				end
			end
			bba_pkg::MODE_FREE: begin
				if (r.block_index < data_floor || r.block_index >= t) begin
					o.status = bba_pkg::ST_INVALID;
				end else if (!occ_map[r.block_index]) begin
					o.status = bba_pkg::ST_DBL_FREE;
				end else begin
					occ_map[r.block_index] = 1'b0;
					if (free_ctr < MAX_BLOCKS)
						free_ctr++;
				end
			end
			default: begin
				o.is_used = (r.block_index >= t) ? 1'b1 : occ_map[r.block_index];
			end
		endcase
		o.free_count = free_ctr[CNT_W-1:0];
		return o;
	endfunction

	function automatic void apply_reg(bba_pkg::cfg_idx_t idx, logic [CNT_W-1:0] v);
		case (idx)
			bba_pkg::CFG_TOTAL_BLOCKS:      vol_total  = v;
			bba_pkg::CFG_FIRST_DATA_BLOCK:  data_floor = v;
			bba_pkg::CFG_INODE_MAP_START:   imap_start = v[BLK_W-1:0];
			bba_pkg::CFG_INODE_MAP_COUNT:   imap_len   = v;
			bba_pkg::CFG_BLOCK_MAP_START:   bmap_start = v[BLK_W-1:0];
			bba_pkg::CFG_BLOCK_MAP_COUNT:   bmap_len   = v;
			bba_pkg::CFG_INODE_TABLE_START: itab_start = v[BLK_W-1:0];
			default:                        itab_len   = v;
		endcase
	endfunction

	function automatic reg_set_t make_regs(int total, int floor_blk, int ims, int imc,
			int bms, int bmc, int its, int itc);
		reg_set_t v;
		v[bba_pkg::CFG_TOTAL_BLOCKS]      = total[CNT_W-1:0];
		v[bba_pkg::CFG_FIRST_DATA_BLOCK]  = floor_blk[CNT_W-1:0];
		v[bba_pkg::CFG_INODE_MAP_START]   = ims[CNT_W-1:0];
		v[bba_pkg::CFG_INODE_MAP_COUNT]   = imc[CNT_W-1:0];
		v[bba_pkg::CFG_BLOCK_MAP_START]   = bms[CNT_W-1:0];
		v[bba_pkg::CFG_BLOCK_MAP_COUNT]   = bmc[CNT_W-1:0];
		v[bba_pkg::CFG_INODE_TABLE_START] = its[CNT_W-1:0];
		v[bba_pkg::CFG_INODE_TABLE_COUNT] = itc[CNT_W-1:0];
		return v;
	endfunction

	// Mostly small volumes so that allocation runs out of room; now and then a
	// full or oversized volume, or fully random values including the top bit.
	function automatic reg_set_t random_regs();
		int t;
		int lim;
		case ($urandom_range(9))
			0: return make_regs($urandom_range(8191), $urandom_range(8191),
					$urandom_range(8191), $urandom_range(8191), $urandom_range(8191),
					$urandom_range(8191), $urandom_range(8191), $urandom_range(8191));
			1: begin
				t = $urandom_range(1) ? MAX_BLOCKS : $urandom_range(MAX_BLOCKS + 1, 8191);
				lim = $urandom_range(40);
				return make_regs(t, $urandom_range(100), $urandom_range(4095),
					$urandom_range(lim), $urandom_range(4095), $urandom_range(lim),
					$urandom_range(4095), $urandom_range(lim));
			end
			2: return make_regs($urandom_range(2), $urandom_range(2), $urandom_range(2),
					$urandom_range(2), $urandom_range(2), $urandom_range(2),
					$urandom_range(2), $urandom_range(2));
			default: begin
				t = $urandom_range(8, $urandom_range(1) ? 40 : 200);
				return make_regs(t, $urandom_range(t / 3), $urandom_range(t),
					$urandom_range(6), $urandom_range(t), $urandom_range(6),
					$urandom_range(t), $urandom_range(6));
			end
		endcase
	endfunction

	function automatic stim_row_t row(bba_pkg::mode_t m, int idx, int set, bit typed,
			bba_pkg::status_t st, int blk, bit used, int fc);
		stim_row_t s;
		s.mode = m;
		s.block_index = idx[BLK_W-1:0];
		s.reg_set = set;
		s.typed = typed;
		s.want.status = st;
		s.want.result_block = blk[BLK_W-1:0];
		s.want.is_used = used;
		s.want.free_count = fc[CNT_W-1:0];
		return s;
	endfunction

	task automatic write_regs(input reg_set_t vals);
		for (int i = 0; i < CFG_REGS; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= bba_pkg::cfg_idx_t'(i);
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			apply_reg(bba_pkg::cfg_idx_t'(i), vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// Valid stays high from one item to the next unless a gap is drawn.
	task automatic send_item(input bba_pkg::req_item_t it, input bit typed,
			input bba_pkg::rsp_item_t want);
		bba_pkg::rsp_item_t got;
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		do @(posedge clk); while (req_stall);
		got = allocator_outcome(it);
		due_rsp_q.push_back(typed ? want : got);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (due_rsp_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_gaps(int send_pct, int recv_pct);
		send_gap_pct = send_pct;
		recv_gap_pct <= recv_pct;
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int hold_left;
		int served;
		hold_left = 0;
		served = 0;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (served != hold_requests) begin
				served = hold_requests;
				hold_left = LONG_HOLD - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= (recv_gap_pct != 0) && ($urandom_range(99) < recv_gap_pct);
			end
		end
	end

	always @(posedge clk) begin
		bba_pkg::rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (due_rsp_q.size() == 0) begin
				$error("response transfer with no request outstanding");
				fail_count++;
			end else begin
				want = due_rsp_q.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp.status);
					fail_count++;
				end
				if (rsp.result_block !== want.result_block) begin
					$error("result_block: expected %0d, actual %0d",
						want.result_block, rsp.result_block);
					fail_count++;
				end
				if (rsp.is_used !== want.is_used) begin
					$error("is_used: expected %0d, actual %0d", want.is_used, rsp.is_used);
					fail_count++;
				end
				if (rsp.free_count !== want.free_count) begin
					$error("free_count: expected %0d, actual %0d",
						want.free_count, rsp.free_count);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL block_bitmap_allocator");
			$finish;
		end
	end

	initial begin
		stim_row_t          directed_q[$];
		reg_set_t           dir_regs[5];
		bba_pkg::req_item_t it;
		bba_pkg::rsp_item_t none;
		int                 items_sent;
		int                 round;
		int                 round_len;
		int                 p;
		int                 k;
		int                 last_freed;
		int                 t;

		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fail_count = 0;
		hold_requests = 0;
		quiet_cycles = 0;
		recv_gap_pct = 0;
		send_gap_pct = 0;
		none = '0;
		last_freed = 0;

		// Register state after reset; the map and counter start cleared.
		occ_map = '0;
		free_ctr = 0;
		vol_total = CNT_W'(MAX_BLOCKS);
		data_floor = '0;
		imap_start = '0;
		imap_len = '0;
		bmap_start = '0;
		bmap_len = '0;
		itab_start = '0;
		itab_len = '0;

		dir_regs[0] = make_regs(MAX_BLOCKS, 0, 0, 0, 0, 0, 0, 0);
		dir_regs[1] = make_regs(40, 8, 1, 2, 3, 1, 4, 4);
		dir_regs[2] = make_regs(10, 9, 0, 0, 0, 0, 0, 0);
		// Oversized total, floor past the end, overlapping and clipped regions.
		dir_regs[3] = make_regs(8191, 4096, 4095, 4096, 4095, 4096, 0, 4096);
		dir_regs[4] = make_regs(0, 0, 0, 0, 0, 0, 0, 0);

		// Fresh map: block 0 is free and the counter sits at zero.
		directed_q.push_back(row(bba_pkg::MODE_QUERY, 0, 0, 1, bba_pkg::ST_OK, 0, 0, 0));
		directed_q.push_back(row(bba_pkg::MODE_ALLOC, 0, -1, 1, bba_pkg::ST_OK, 0, 0, 0));
		directed_q.push_back(row(bba_pkg::MODE_FREE, 0, -1, 1, bba_pkg::ST_OK, 0, 0, 1));
		directed_q.push_back(row(bba_pkg::MODE_FREE, 0, -1, 1, bba_pkg::ST_DBL_FREE,
			0, 0, 1));
		directed_q.push_back(row(bba_pkg::MODE_INIT, 0, -1, 1, bba_pkg::ST_OK, 0, 0, 4095));
		directed_q.push_back(row(bba_pkg::MODE_FREE, 0, -1, 1, bba_pkg::ST_OK, 0, 0, 4096));
		directed_q.push_back(row(bba_pkg::MODE_ALLOC, 4095, -1, 1, bba_pkg::ST_OK,
			0, 0, 4095));
		directed_q.push_back(row(bba_pkg::MODE_ALLOC, 0, -1, 1, bba_pkg::ST_OK, 1, 0, 4094));
		directed_q.push_back(row(bba_pkg::MODE_FREE, 4095, -1, 1, bba_pkg::ST_DBL_FREE,
			0, 0, 4094));
		directed_q.push_back(row(bba_pkg::MODE_INIT, 0, 1, 1, bba_pkg::ST_OK, 0, 0, 32));
		directed_q.push_back(row(bba_pkg::MODE_FREE, 7, -1, 1, bba_pkg::ST_INVALID,
			0, 0, 32));
		directed_q.push_back(row(bba_pkg::MODE_FREE, 40, -1, 1, bba_pkg::ST_INVALID,
			0, 0, 32));
		directed_q.push_back(row(bba_pkg::MODE_QUERY, 40, -1, 1, bba_pkg::ST_OK, 0, 1, 32));
		directed_q.push_back(row(bba_pkg::MODE_QUERY, 4, -1, 0, bba_pkg::ST_OK, 0, 0, 0));
		directed_q.push_back(row(bba_pkg::MODE_ALLOC, 0, -1, 0, bba_pkg::ST_OK, 0, 0, 0));
		directed_q.push_back(row(bba_pkg::MODE_INIT, 0, 2, 1, bba_pkg::ST_OK, 0, 0, 9));
		directed_q.push_back(row(bba_pkg::MODE_ALLOC, 0, -1, 0, bba_pkg::ST_OK, 0, 0, 0));
		directed_q.push_back(row(bba_pkg::MODE_ALLOC, 0, -1, 1, bba_pkg::ST_NO_SPACE,
			0, 0, 8));
		directed_q.push_back(row(bba_pkg::MODE_INIT, 0, 3, 1, bba_pkg::ST_OK, 0, 0, 0));
		directed_q.push_back(row(bba_pkg::MODE_ALLOC, 0, -1, 1, bba_pkg::ST_NO_SPACE,
			0, 0, 0));
		directed_q.push_back(row(bba_pkg::MODE_QUERY, 4095, -1, 1, bba_pkg::ST_OK,
			0, 1, 0));
		directed_q.push_back(row(bba_pkg::MODE_INIT, 0, 4, 1, bba_pkg::ST_OK, 0, 0, 0));
		directed_q.push_back(row(bba_pkg::MODE_QUERY, 0, -1, 1, bba_pkg::ST_OK, 0, 1, 0));
		directed_q.push_back(row(bba_pkg::MODE_FREE, 0, -1, 1, bba_pkg::ST_INVALID,
			0, 0, 0));
		directed_q.push_back(row(bba_pkg::MODE_ALLOC, 0, -1, 1, bba_pkg::ST_NO_SPACE,
			0, 0, 0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		set_gaps(14, 50);
		foreach (directed_q[i]) begin
			if (directed_q[i].reg_set >= 0) begin
				drain();
				write_regs(dir_regs[directed_q[i].reg_set]);
			end
			it.mode = directed_q[i].mode;
			it.block_index = directed_q[i].block_index;
			send_item(it, directed_q[i].typed, directed_q[i].want);
		end
		drain();

		items_sent = 0;
		round = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent < RANDOM_ITEMS / 3)
				set_gaps(14, 50);
			else if (items_sent < 2 * RANDOM_ITEMS / 3)
				set_gaps(50, 14);
			else
				set_gaps(0, 0);
			write_regs(random_regs());
			it.mode = bba_pkg::MODE_INIT;
			it.block_index = BLK_W'($urandom_range(4095));
			send_item(it, 1'b0, none);
			// One long hold-off on the response side while requests keep coming.
			if (round == 4)
				hold_requests <= hold_requests + 1;
			round_len = $urandom_range(30, 70);
			t = volume_size();
			for (int n = 0; n < round_len; n++) begin
				p = $urandom_range(99);
				it.block_index = BLK_W'($urandom_range(4095));
				if (p < 45) begin
					it.mode = bba_pkg::MODE_ALLOC;
				end else if (p < 75) begin
					it.mode = bba_pkg::MODE_FREE;
					k = $urandom_range(9);
					if (k < 7 && granted_q.size() != 0) begin
						k = $urandom_range(granted_q.size() - 1);
						it.block_index = BLK_W'(granted_q[k]);
						granted_q.delete(k);
						last_freed = it.block_index;
					end else if (k < 8) begin
						it.block_index = BLK_W'(last_freed);
					end
				end else if (p < 90) begin
					it.mode = bba_pkg::MODE_QUERY;
					if ($urandom_range(1))
						it.block_index = BLK_W'($urandom_range((t + 3 > 4095) ? 4095 : t + 3));
				end else if (p < 93) begin
					it.mode = bba_pkg::MODE_INIT;
				end else begin
					it.mode = bba_pkg::mode_t'($urandom_range(3));
				end
				send_item(it, 1'b0, none);
			end
			items_sent += round_len + 1;
			round++;
			drain();
		end

		if (fail_count == 0)
			$display("PASS block_bitmap_allocator");
		else
			$display("FAIL block_bitmap_allocator");
		$finish;
	end

endmodule
